/* rtl/wlcp_pkg.sv */
// Shared types and constants of the weighted least-connections picker.
`timescale 1ns / 1ps
`default_nettype none
package wlcp_pkg;

    localparam int NumPeers   = 16;
    localparam int WeightBits = 8;
    localparam int ConnBits   = 16;
    localparam int IdxBits    = $clog2(NumPeers);
    localparam int CntBits    = $clog2(NumPeers + 1);
    localparam int CwBits     = 16;
    localparam int ProdBits   = ConnBits + WeightBits;

    localparam logic [2:0] FUNC_WRITE    = 3'd0;
    localparam logic [2:0] FUNC_PICK     = 3'd1;
    localparam logic [2:0] FUNC_RELEASE  = 3'd2;
    localparam logic [2:0] FUNC_ELIGIBLE = 3'd3;
    localparam logic [2:0] FUNC_NEW_REQ  = 3'd4;

    localparam logic [1:0] STATUS_CHOSEN = 2'd0;
    localparam logic [1:0] STATUS_BUSY   = 2'd1;
    localparam logic [1:0] STATUS_ACK    = 2'd2;

    typedef struct packed {
        logic [2:0]            func;
        logic [3:0]            peer_slot;
        logic [7:0]            weight_value;
        logic                  backup_value;
        logic                  eligible_value;
    } wlcp_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] chosen_peer;
        logic       from_backup;
    } wlcp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TIE_START,
        ST_TIE,
        ST_FINISH,
        ST_AFTER_TIER,
        ST_OUT
    } wlcp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture item, run simple ops
        logic scan_start;   // start pass 1 at entry 0
        logic scan_step;    // pass 1 step at index
        logic tie_start;    // start pass 2 at first
        logic tie_step;     // pass 2 step at index
        logic finish;       // commit winner
        logic go_backup;    // switch tier, clear tried marks
        logic set_busy;
        logic set_chosen;
    } wlcp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_pick;
        logic on_backup;
        logic scan_last;    // index is the last in-use entry (or none in use)
        logic found;
        logic many;
        logic has_backup;
    } wlcp_sts_t;

endpackage
`default_nettype wire

/* rtl/wlcp_datapath.sv */
// Peer table, compare arithmetic and winner bookkeeping of the picker.
`timescale 1ns / 1ps
`default_nettype none
module wlcp_datapath
    import wlcp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [4:0]       cfg_data,
    input  wire wlcp_in_t         item,
    input  wire wlcp_cmd_t        cmd,
    output wlcp_sts_t             sts,
    output wlcp_out_t             result
);

    logic [WeightBits-1:0] weight_reg [NumPeers];
    logic [WeightBits-1:0] eff_reg    [NumPeers];
    logic [CwBits-1:0]     cw_reg     [NumPeers];
    logic [ConnBits-1:0]   conns_reg  [NumPeers];
    logic [NumPeers-1:0]   elig_reg, backup_reg, tried_reg;
    logic                  on_backup_reg;
    logic [4:0]            in_use_reg;
    wlcp_in_t              item_reg;
    wlcp_out_t             result_reg;

    logic [IdxBits-1:0]    idx_reg, best_reg, first_reg;
    logic                  found_reg, many_reg;
    logic [CwBits+IdxBits:0] total_reg;

    logic [CntBits-1:0]    n_act;
    logic                  usable;
    logic [ProdBits-1:0]   lhs, rhs;
    logic                  any_backup;
    logic signed [CwBits+1:0] cw_inc, cw_dec;
    logic signed [CwBits-1:0] cw_new;

    localparam logic signed [CwBits+1:0] CwMax = (CwBits+2)'((1 << (CwBits-1)) - 1);
    localparam logic signed [CwBits+1:0] CwMin = -(CwBits+2)'(1 << (CwBits-1));

    function automatic logic signed [CwBits-1:0] sat_cw(input logic signed [CwBits+1:0] v);
        if (v > CwMax)
            return CwMax[CwBits-1:0];
        else if (v < CwMin)
            return CwMin[CwBits-1:0];
        else
            return v[CwBits-1:0];
    endfunction

    always_comb
    begin
        n_act = (in_use_reg > 5'(NumPeers)) ? CntBits'(NumPeers) : CntBits'(in_use_reg);
        // entries past the in-use count never take part
        usable = (CntBits'(idx_reg) < n_act)
                 && (backup_reg[idx_reg] == on_backup_reg) && !tried_reg[idx_reg]
                 && elig_reg[idx_reg];
        lhs = ProdBits'(conns_reg[idx_reg]) * ProdBits'(weight_reg[first_reg]);
        rhs = ProdBits'(conns_reg[first_reg]) * ProdBits'(weight_reg[idx_reg]);
        any_backup = 1'b0;
        for (int i = 0; i < NumPeers; i++)
        begin
            if (CntBits'(i) < n_act && backup_reg[i])
                any_backup = 1'b1;
        end
        cw_inc = (CwBits+2)'(signed'(cw_reg[idx_reg])) + (CwBits+2)'(eff_reg[idx_reg]);
        cw_new = sat_cw(cw_inc);
        cw_dec = (CwBits+2)'(signed'(cw_reg[best_reg]))
                 - ((total_reg > (CwBits+IdxBits+1)'(1 << CwBits))
                    ? (CwBits+2)'(1 << CwBits) : (CwBits+2)'(total_reg));
    end

    assign sts.is_pick    = item_reg.func == FUNC_PICK;
    assign sts.on_backup  = on_backup_reg;
    assign sts.scan_last  = (n_act == '0) || (CntBits'(idx_reg) + 1'b1 >= n_act);
    assign sts.found      = found_reg;
    assign sts.many       = many_reg;
    assign sts.has_backup = any_backup;
    assign result         = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumPeers; i++)
            begin
                weight_reg[i] <= WeightBits'(1);
                eff_reg[i]    <= WeightBits'(1);
                cw_reg[i]     <= '0;
                conns_reg[i]  <= '0;
            end
            elig_reg      <= '1;
            backup_reg    <= '0;
            tried_reg     <= '0;
            on_backup_reg <= 1'b0;
            in_use_reg    <= 5'd16;
        end
        else
        begin
            if (cfg_we)
                in_use_reg <= cfg_data;
            if (cmd.load)
            begin
                unique case (item.func)
                    FUNC_WRITE:
                    begin
                        weight_reg[item.peer_slot] <= (item.weight_value == '0)
                            ? WeightBits'(1) : item.weight_value[WeightBits-1:0];
                        eff_reg[item.peer_slot] <= (item.weight_value == '0)
                            ? WeightBits'(1) : item.weight_value[WeightBits-1:0];
                        cw_reg[item.peer_slot] <= '0;
                        backup_reg[item.peer_slot] <= item.backup_value;
                    end
                    FUNC_RELEASE:
                    begin
                        if (conns_reg[item.peer_slot] != '0)
                            conns_reg[item.peer_slot] <= conns_reg[item.peer_slot] - 1'b1;
                    end
                    FUNC_ELIGIBLE: elig_reg[item.peer_slot] <= item.eligible_value;
                    FUNC_NEW_REQ:
                    begin
                        tried_reg     <= '0;
                        on_backup_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.tie_step && usable && lhs == rhs)
            begin
                cw_reg[idx_reg] <= cw_new;
                if (eff_reg[idx_reg] < weight_reg[idx_reg])
                    eff_reg[idx_reg] <= eff_reg[idx_reg] + 1'b1;
            end
            if (cmd.finish)
            begin
                cw_reg[best_reg] <= sat_cw(cw_dec);
                if (conns_reg[best_reg] != '1)
                    conns_reg[best_reg] <= conns_reg[best_reg] + 1'b1;
                tried_reg[best_reg] <= 1'b1;
            end
            if (cmd.go_backup)
            begin
                on_backup_reg <= 1'b1;
                tried_reg     <= '0;
            end
        end
    end

    // Scan registers and result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            best_reg   <= '0;
            first_reg  <= '0;
            found_reg  <= 1'b0;
            many_reg   <= 1'b0;
            total_reg  <= '0;
            item_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                item_reg   <= item;
                result_reg <= '{status: STATUS_ACK, chosen_peer: '0, from_backup: 1'b0};
            end
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                many_reg  <= 1'b0;
                total_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (usable)
                begin
                    if (!found_reg || lhs < rhs)
                    begin
                        best_reg  <= idx_reg;
                        first_reg <= idx_reg;
                        many_reg  <= 1'b0;
                        found_reg <= 1'b1;
                    end
                    else if (lhs == rhs)
                        many_reg <= 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.tie_start)
                idx_reg <= first_reg;
            if (cmd.tie_step)
            begin
                if (usable && lhs == rhs)
                begin
                    total_reg <= total_reg + (CwBits+IdxBits+1)'(eff_reg[idx_reg]);
                    if (signed'(cw_new) > signed'(cw_reg[best_reg]) && idx_reg != best_reg)
                        best_reg <= idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.set_busy)
                result_reg <= '{status: STATUS_BUSY, chosen_peer: '0, from_backup: 1'b0};
            if (cmd.set_chosen)
                result_reg <= '{status: STATUS_CHOSEN, chosen_peer: 4'(best_reg),
                                from_backup: on_backup_reg};
        end
    end

endmodule
`default_nettype wire

/* rtl/wlcp_ctrl.sv */
// Sequencer of the picker: handshake, scan passes and tier switch.
`timescale 1ns / 1ps
`default_nettype none
module wlcp_ctrl
    import wlcp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire wlcp_sts_t sts,
    output wlcp_cmd_t      cmd
);

    wlcp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_AFTER_TIER;
                end
            end
            ST_AFTER_TIER:
            begin
                // a pick starts the scan of the current tier
                if (!sts.is_pick)
                    state_next = ST_OUT;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_TIE_START;
            end
            ST_TIE_START:
            begin
                if (!sts.found)
                begin
                    if (!sts.on_backup && sts.has_backup)
                    begin
                        cmd.go_backup  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.set_busy = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
                else if (sts.many)
                begin
                    cmd.tie_start = 1'b1;
                    state_next    = ST_TIE;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_TIE:
            begin
                cmd.tie_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish     = 1'b1;
                cmd.set_chosen = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/weighted_least_conn_picker_core.sv */
// Top level of the weighted least-connections peer picker.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | in_data  (wlcp_in_t)
//  out     | out_valid | out_stall | out_data (wlcp_out_t)
//  cfg     | cfg_we    | -         | cfg_data (peers_in_use)
//
// A non-pick item goes from the idle state through ST_AFTER_TIER to ST_OUT. A
// pick scans the peers in use on its tier (at least one entry), scans the backup
// tier as well when it falls through to it, and runs the round-robin pass when
// ties need it; a busy answer skips ST_FINISH. One comparison per cycle against the peer table.
// Reset restores the whole table directly; no clearing pass.
// The result holds in out_data while out_stall is high; no item is taken then.
`timescale 1ns / 1ps
`default_nettype none
module weighted_least_conn_picker_core
    import wlcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire wlcp_in_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output wlcp_out_t       out_data
);

    wlcp_cmd_t cmd;
    wlcp_sts_t sts;

    wlcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    wlcp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .result   (out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input taken while a result is pending");
    a_busy_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_BUSY |-> out_data.chosen_peer == '0)
        else $error("busy result carries a peer");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
